@@ rtl/osv_pkg.sv @@
package osv_pkg;

   // mode codes
   localparam logic [1:0] MODE_PLAIN = 2'd0;
   localparam logic [1:0] MODE_BS    = 2'd1;
   localparam logic [1:0] MODE_MARK  = 2'd2;

   // longest run of result bytes for one item: prefix, M, -, ^, byte
   localparam int RUN_MAX = 5;
   localparam int CNT_W   = 3;

   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_M     = 8'h4D;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_CARET = 8'h5E;
   localparam logic [7:0] CH_DEL7  = 8'h7F;
   localparam logic [7:0] CH_CTL   = 8'h20;
   localparam logic [7:0] CH_FLIP  = 8'h40;
   localparam logic [7:0] CH_LOW7  = 8'h7F;

   typedef logic [RUN_MAX-1:0][7:0] run_bytes_type;

   // translation result for one item plus the state it leaves
   typedef struct packed {
      run_bytes_type    bytes;
      logic [CNT_W-1:0] count;
      logic [1:0]       mode;
      logic [7:0]       held;
   } run_type;

   function automatic logic is_mark(input logic [7:0] c);
      is_mark = (c == 8'h27) || (c == 8'h60) || (c == 8'h5E) || (c == 8'h22) ||
                (c == 8'h7E) || (c == 8'h2C) || (c == 8'h5F);
   endfunction

endpackage

@@ rtl/osv_xlate.sv @@
module osv_xlate (
   input  logic [7:0]       data_byte,
   input  logic             end_of_stream,
   input  logic [1:0]       mode,
   input  logic [7:0]       held_mark,
   output osv_pkg::run_type run
);

   logic                          pre_en;
   logic [7:0]                    pre_byte;
   logic                          do_plain;
   logic                          meta_en;
   logic                          caret_en;
   logic                          body_en;
   logic [7:0]                    body_byte;
   logic [6:0]                    low7;
   logic                          ctl;
   logic [1:0]                    nx_mode;
   logic [7:0]                    nx_held;
   logic [osv_pkg::RUN_MAX-1:0]   slot_en;
   osv_pkg::run_bytes_type        slot;
   logic [osv_pkg::CNT_W-1:0]     k;

   assign low7 = data_byte[6:0];
   assign ctl  = ({1'b0, low7} < osv_pkg::CH_CTL) || ({1'b0, low7} == osv_pkg::CH_DEL7);

   always_comb begin
      pre_en    = 1'b0;
      pre_byte  = osv_pkg::CH_BS;
      do_plain  = 1'b0;
      nx_mode   = osv_pkg::MODE_PLAIN;
      nx_held   = held_mark;
      meta_en   = 1'b0;
      caret_en  = 1'b0;
      body_en   = 1'b0;
      body_byte = data_byte;

      if (end_of_stream) begin
         nx_held = 8'd0;
         if (mode == osv_pkg::MODE_BS) begin
            pre_en = 1'b1;
         end else if (mode == osv_pkg::MODE_MARK) begin
            pre_en   = 1'b1;
            pre_byte = held_mark;
         end
      end else begin
         unique case (mode)
            osv_pkg::MODE_BS: begin
               if (!osv_pkg::is_mark(data_byte)) begin
                  pre_en   = 1'b1;
                  do_plain = 1'b1;
               end
            end
            osv_pkg::MODE_MARK: begin
               nx_held = 8'd0;
               if (data_byte != osv_pkg::CH_BS) begin
                  pre_en   = 1'b1;
                  pre_byte = held_mark;
                  do_plain = 1'b1;
               end
            end
            default: begin
               do_plain = 1'b1;
            end
         endcase
      end

      // plain handling of the current byte
      if (do_plain) begin
         if (data_byte == osv_pkg::CH_NL || data_byte == osv_pkg::CH_TAB) begin
            body_en = 1'b1;
         end else if (data_byte == osv_pkg::CH_BS) begin
            nx_mode = osv_pkg::MODE_BS;
         end else if (osv_pkg::is_mark(data_byte)) begin
            nx_held = data_byte;
            nx_mode = osv_pkg::MODE_MARK;
         end else begin
            meta_en   = data_byte[7];
            caret_en  = ctl;
            body_en   = 1'b1;
            body_byte = {1'b0, low7} ^ (ctl ? osv_pkg::CH_FLIP : 8'd0);
         end
      end
   end

   // candidate slots in output order, then packed to the front
   assign slot_en = {body_en, caret_en, meta_en, meta_en, pre_en};
   assign slot    = {body_byte, osv_pkg::CH_CARET, osv_pkg::CH_DASH, osv_pkg::CH_M, pre_byte};

   always_comb begin
      k         = '0;
      run.bytes = '0;
      run.mode  = nx_mode;
      run.held  = nx_held;
      for (int i = 0; i < osv_pkg::RUN_MAX; i++) begin
         if (slot_en[i]) begin
            run.bytes[k] = slot[i];
            k            = k + 1'b1;
         end
      end
      run.count = k;
   end

endmodule

@@ rtl/overstrike_strip_visible_ascii_unit.sv @@
// channel  ports                                      direction
// req      req_valid req_stall req_data_byte          in (stall out)
//          req_end_of_stream
// rsp      rsp_valid rsp_stall rsp_out_byte           out (stall in)
//          rsp_last_of_run
//
// an item is translated in the cycle it is accepted; its run of 0 to 5 bytes
// lands in a run register and leaves one byte per cycle from the front while rsp_stall is low
// sustained rate is one item per cycle while each item yields at most one byte and rsp_stall is low;
// an item yielding more than one byte stalls the input while the run drains
// reset is synchronous, active high: plain mode, no mark held, run register empty
// req_stall is high while more than the last byte waits, or the last byte is stalled
module overstrike_strip_visible_ascii_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_stream,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run
);

   // overstrike state
   logic [1:0]                 mode_ff, mode_in;
   logic [7:0]                 held_mark_ff, held_mark_in;

   // run register: bytes waiting to go out, front at index 0
   osv_pkg::run_bytes_type     run_ff, run_in;
   logic [osv_pkg::CNT_W-1:0]  count_ff, count_in;

   osv_pkg::run_type           xl;
   logic                       req_take;
   logic                       rsp_take;

   osv_xlate u_xlate (
      .data_byte     (req_data_byte),
      .end_of_stream (req_end_of_stream),
      .mode          (mode_ff),
      .held_mark     (held_mark_ff),
      .run           (xl)
   );

   // output side
   assign rsp_valid       = (count_ff != '0);
   assign rsp_out_byte    = run_ff[0];
   assign rsp_last_of_run = (count_ff == osv_pkg::CNT_W'(1));
   assign rsp_take        = rsp_valid && !rsp_stall;

   // take a new item once the run register is empty or its last byte leaves now
   assign req_stall = rsp_valid && !(rsp_last_of_run && !rsp_stall);
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      mode_in      = mode_ff;
      held_mark_in = held_mark_ff;
      run_in       = run_ff;
      count_in     = count_ff;
      if (req_take) begin
         mode_in      = xl.mode;
         held_mark_in = xl.held;
         run_in       = xl.bytes;
         count_in     = xl.count;
      end else if (rsp_take) begin
         // shift the next byte to the front
         run_in   = {8'd0, run_ff[osv_pkg::RUN_MAX-1:1]};
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= osv_pkg::MODE_PLAIN;
         held_mark_ff <= 8'd0;
         count_ff     <= '0;
      end else begin
         mode_ff      <= mode_in;
         held_mark_ff <= held_mark_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff <= run_in;
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= osv_pkg::CNT_W'(osv_pkg::RUN_MAX))
      else $error("run count out of range");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      req_take |-> (count_ff == '0) || (count_ff == osv_pkg::CNT_W'(1) && !rsp_stall))
      else $error("item accepted over a pending run");

   a_mark_held: assert property (@(posedge clock) disable iff (reset)
      mode_ff == osv_pkg::MODE_MARK |-> osv_pkg::is_mark(held_mark_ff))
      else $error("mark mode without an accent mark held");

   a_held_clear: assert property (@(posedge clock) disable iff (reset)
      mode_ff != osv_pkg::MODE_MARK |-> held_mark_ff == 8'd0)
      else $error("held mark not cleared outside mark mode");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_take && !req_take |=> count_ff == $past(count_ff) - 1'b1)
      else $error("run count did not step down on delivery");
`endif

endmodule
